[hdl/serpentine_dither_palette_mapper_defines.svh]
// Assertion macros used by the checker of the palette mapper.
`ifndef SERPENTINE_DITHER_PALETTE_MAPPER_DEFINES_SVH
`define SERPENTINE_DITHER_PALETTE_MAPPER_DEFINES_SVH

// Clocked assertion, masked while reset is high.
`define SDPM_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define SDPM_ASSERT_RST(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

[hdl/sdpm_pkg.sv]
// Shared types, constants and helpers of the serpentine dither palette mapper.
`default_nettype none
package sdpm_pkg;

   localparam int MAX_WIDTH    = 2048;
   localparam int ROW_SLOTS    = MAX_WIDTH + 2;
   localparam int ADDR_W       = $clog2(ROW_SLOTS);
   localparam int PASS_W       = $clog2(ROW_SLOTS + 1);
   localparam int COL_W        = 12;
   localparam int PAL_DEPTH    = 256;
   localparam int IDX_W        = 8;
   localparam int CNT_W        = 9;
   localparam int CELL_COUNT   = 16;
   localparam int CELL_ENTRIES = PAL_DEPTH / CELL_COUNT;
   localparam int SLOT_W       = $clog2(CELL_ENTRIES);
   localparam int CELL_SEL_W   = $clog2(CELL_COUNT);
   localparam int ERROR_SCALE  = 1024;
   localparam int ERR_SHIFT    = $clog2(ERROR_SCALE);
   localparam int ERR_W        = 20;
   localparam int DIST_W       = 18;
   localparam int SQ_W         = 16;
   localparam int DIFF_W       = 9;
   localparam int EPOCH_W      = 8;
   localparam int EPOCH_LIMIT  = (1 << EPOCH_W) - 4;
   // search: slot steps, two cell stages, then the ripple along the chain
   localparam int SCAN_LAST    = CELL_ENTRIES + 2 + CELL_COUNT - 1;
   localparam int SCAN_W       = $clog2(SCAN_LAST + 1);

   // error shares in sixteenths, pre-scaled
   localparam int SHARE_7 = 7 * ERROR_SCALE / 16;
   localparam int SHARE_3 = 3 * ERROR_SCALE / 16;
   localparam int SHARE_5 = 5 * ERROR_SCALE / 16;
   localparam int SHARE_1 = 1 * ERROR_SCALE / 16;

   typedef enum logic [1:0] {
      ACT_LOAD  = 2'd0,
      ACT_PIXEL = 2'd1,
      ACT_FRAME = 2'd2
   } action_type;

   localparam logic [1:0] REG_ROW_WIDTH     = 2'd0;
   localparam logic [1:0] REG_MAX_LEVEL     = 2'd1;
   localparam logic [1:0] REG_PALETTE_COUNT = 2'd2;
   localparam logic [1:0] REG_DITHER_ENABLE = 2'd3;

   typedef logic [2:0][7:0] rgb_type;   // [0] red, [1] green, [2] blue

   typedef struct packed {
      logic [EPOCH_W-1:0]          tag;
      logic [2:0][ERR_W-1:0]       err;
   } err_word_type;

   localparam int ERR_WORD_W = $bits(err_word_type);

   typedef struct packed {
      logic [DIST_W-1:0] distance;
      logic [IDX_W-1:0]  idx;
      rgb_type           rgb;
   } cand_type;

   localparam cand_type CAND_NONE = '1;

   typedef struct packed {
      logic              clear;
      logic              step;
      logic [SLOT_W-1:0] slot;
      logic [CNT_W-1:0]  count;
      logic              load;
      logic [IDX_W-1:0]  load_idx;
      rgb_type           load_rgb;
      rgb_type           pix;
   } cell_ctl_type;

   // lower distance wins, equal distance goes to the lower palette index
   function automatic logic better(input cand_type a, input cand_type b);
      return (a.distance < b.distance) ||
             ((a.distance == b.distance) && (a.idx < b.idx));
   endfunction

endpackage
`default_nettype wire

[hdl/sdpm_ram.sv]
// Generic simple dual-port RAM with registered read.
`default_nettype none
module sdpm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule
`default_nettype wire

[hdl/sdpm_cell.sv]
// One search cell: holds a slice of the palette and its running best.
`default_nettype none
module sdpm_cell
   import sdpm_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [CELL_SEL_W-1:0] cell_id,
   input  wire cell_ctl_type          ctl,
   input  wire cand_type              chain_in,
   output      cand_type              chain_out
);

   rgb_type             pal_ff [CELL_ENTRIES];
   logic [2:0][SQ_W-1:0] sq_ff;
   logic                s1_valid_ff;
   logic [IDX_W-1:0]    s1_idx_ff;
   rgb_type             s1_rgb_ff;
   cand_type            local_ff;
   cand_type            chain_ff;

   rgb_type             entry;
   logic [IDX_W-1:0]    entry_idx;
   logic [2:0][SQ_W-1:0] sq;
   logic [DIST_W-1:0]   sq_sum;

   assign entry     = pal_ff[ctl.slot];
   assign entry_idx = {ctl.slot, cell_id};
   assign sq_sum    = DIST_W'(sq_ff[0]) + DIST_W'(sq_ff[1]) + DIST_W'(sq_ff[2]);
   assign chain_out = chain_ff;

   always_comb begin
      logic signed [DIFF_W-1:0]     d;
      logic signed [2*DIFF_W-1:0]   p;
      for (int c = 0; c < 3; c++) begin
         d     = $signed({1'b0, ctl.pix[c]}) - $signed({1'b0, entry[c]});
         p     = d * d;
         sq[c] = p[SQ_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load && (ctl.load_idx[CELL_SEL_W-1:0] == cell_id)) begin
         pal_ff[ctl.load_idx[IDX_W-1:CELL_SEL_W]] <= ctl.load_rgb;
      end
      sq_ff     <= sq;
      s1_idx_ff <= entry_idx;
      s1_rgb_ff <= entry;
      if (ctl.clear) begin
         local_ff <= CAND_NONE;
      end else if (s1_valid_ff && (sq_sum < local_ff.distance)) begin
         local_ff <= '{distance: sq_sum, idx: s1_idx_ff, rgb: s1_rgb_ff};
      end
      chain_ff <= better(local_ff, chain_in) ? local_ff : chain_in;
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= ctl.step && ({1'b0, entry_idx} < ctl.count);
      end
   end

endmodule
`default_nettype wire

[hdl/serpentine_dither_palette_mapper.sv]
// Top level of the serpentine Floyd-Steinberg palette mapper.
`default_nettype none
// Maps RGB pixels to the nearest entry of a 256-slot palette, optionally with
// serpentine Floyd-Steinberg error diffusion. Each req transaction is a palette
// load, a start of frame or a pixel (kind in req_tuser); only pixels produce a
// rsp transaction. The search for a pixel runs through a chain of 16 cells,
// each owning 16 palette slots, one slot per cell per cycle, then the best
// candidate ripples cell to cell down the chain. Dithering adds one read of
// the current error row and four read-modify-writes of the error rows,
// serialized on the RAM port of each row bank. The two error rows live in two
// RAM banks that swap at each dithered row end; entries carry an epoch tag so
// a row is cleared by changing its epoch. After reset, and whenever the epoch
// counter nears its end (about every 250 dithered row ends, a frame start
// counting as two), a pass sweeps both banks during which no req transaction
// is taken; csr writes are always taken. Result register: the next item is
// accepted while a result waits on rsp.
module serpentine_dither_palette_mapper
   import sdpm_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [31:0] req_tdata,   // entry_index, red, green, blue
   input  wire logic [1:0]  req_tuser,   // action
   // result channel
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [31:0] rsp_tdata,   // color_index, out_red, out_green, out_blue
   output      logic        rsp_tlast,   // row_end
   // configuration write channel
   input  wire logic        csr_valid,
   output      logic        csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [11:0] csr_data
);

   typedef enum logic [2:0] {
      ST_PASS, ST_IDLE, ST_RD, ST_ADJ, ST_SCAN, ST_UPD_RD, ST_UPD_WR, ST_DONE
   } state_type;

   // configuration
   logic [COL_W-1:0]   row_width_ff;
   logic [7:0]         max_level_ff;
   logic [CNT_W-1:0]   pal_count_ff;
   logic               dither_ff;

   // control
   state_type          state_ff;
   logic [PASS_W-1:0]  pass_cnt_ff;
   logic               pass_wipe_ff;
   logic [SCAN_W-1:0]  scan_cnt_ff;
   logic [1:0]         upd_ff;
   logic [COL_W-1:0]   colpos_ff;
   logic               scan_fwd_ff;
   logic               cur_sel_ff;
   logic [EPOCH_W-1:0] ep_ff [2];
   logic [EPOCH_W-1:0] ep_next_ff;
   logic               rsp_valid_ff;

   // per-pixel payload
   rgb_type            pix_ff;
   rgb_type            adj_ff;
   logic [COL_W-1:0]   pos_ff;
   logic [COL_W-1:0]   col_ff;
   logic               fwd_ff;
   logic               last_ff;
   logic               dith_ff;
   cand_type           best_ff;
   logic [2:0][DIFF_W-1:0] diff_ff;
   logic [31:0]        rsp_data_ff;
   logic               rsp_last_ff;

   // RAM ports
   logic               wr_en   [2];
   logic [ADDR_W-1:0]  wr_addr [2];
   err_word_type       wr_data [2];
   logic [ADDR_W-1:0]  rd_addr [2];
   err_word_type       rd_data [2];

   // cell chain
   cell_ctl_type       ctl;
   cand_type           chain [CELL_COUNT];

   logic               req_fire;
   action_type         req_act;
   logic [COL_W-1:0]   width_eff;
   logic [CNT_W-1:0]   count_eff;
   logic [COL_W-1:0]   pos_sel;
   logic               fwd_sel;
   logic [COL_W-1:0]   col_sel;
   rgb_type            adj_in;
   logic [2:0][DIFF_W-1:0] diff_in;
   logic               tgt_bank;
   logic [ADDR_W-1:0]  tgt_addr;
   logic [ERR_W-1:0]   tgt_k;
   err_word_type       upd_word;
   logic               out_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign req_act    = action_type'(req_tuser);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // clamp the row width and entry count to what the store holds
   always_comb begin
      if (row_width_ff == '0) begin
         width_eff = COL_W'(1);
      end else if (row_width_ff > COL_W'(MAX_WIDTH)) begin
         width_eff = COL_W'(MAX_WIDTH);
      end else begin
         width_eff = row_width_ff;
      end
      if (pal_count_ff == '0) begin
         count_eff = CNT_W'(1);
      end else if (pal_count_ff > CNT_W'(PAL_DEPTH)) begin
         count_eff = CNT_W'(PAL_DEPTH);
      end else begin
         count_eff = pal_count_ff;
      end
      // a width shrunk below the position ends the row here
      pos_sel = (colpos_ff >= width_eff) ? width_eff - COL_W'(1) : colpos_ff;
      fwd_sel = !dither_ff || scan_fwd_ff;
      col_sel = fwd_sel ? pos_sel : width_eff - COL_W'(1) - pos_sel;
   end

   // stored error / ERROR_SCALE (toward zero), added and clamped
   always_comb begin
      err_word_type            w;
      logic signed [ERR_W-1:0] e;
      logic signed [ERR_W-1:0] q;
      logic signed [ERR_W-1:0] s;
      w = rd_data[cur_sel_ff];
      for (int c = 0; c < 3; c++) begin
         e = (w.tag == ep_ff[cur_sel_ff]) ? $signed(w.err[c]) : '0;
         q = e >>> ERR_SHIFT;
         if (e[ERR_W-1] && (e[ERR_SHIFT-1:0] != '0)) begin
            q = q + ERR_W'(1);
         end
         s = $signed({{(ERR_W-8){1'b0}}, pix_ff[c]}) + q;
         if (s[ERR_W-1]) begin
            adj_in[c] = '0;
         end else if (s > $signed({{(ERR_W-8){1'b0}}, max_level_ff})) begin
            adj_in[c] = max_level_ff;
         end else begin
            adj_in[c] = s[7:0];
         end
      end
   end

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         diff_in[c] = $signed({1'b0, adj_ff[c]}) - $signed({1'b0, chain[CELL_COUNT-1].rgb[c]});
      end
   end

   // the four error updates of one pixel: 7/16 ahead, 3, 5, 1 below
   always_comb begin
      logic [COL_W-1:0] ahead;
      logic [COL_W-1:0] behind;
      ahead  = fwd_ff ? col_ff + COL_W'(2) : col_ff;
      behind = fwd_ff ? col_ff : col_ff + COL_W'(2);
      unique case (upd_ff)
         2'd0: begin
            tgt_bank = cur_sel_ff;
            tgt_addr = ADDR_W'(ahead);
            tgt_k    = ERR_W'(SHARE_7);
         end
         2'd1: begin
            tgt_bank = !cur_sel_ff;
            tgt_addr = ADDR_W'(behind);
            tgt_k    = ERR_W'(SHARE_3);
         end
         2'd2: begin
            tgt_bank = !cur_sel_ff;
            tgt_addr = ADDR_W'(col_ff + COL_W'(1));
            tgt_k    = ERR_W'(SHARE_5);
         end
         default: begin
            tgt_bank = !cur_sel_ff;
            tgt_addr = ADDR_W'(ahead);
            tgt_k    = ERR_W'(SHARE_1);
         end
      endcase
   end

   always_comb begin
      err_word_type            w;
      logic signed [ERR_W-1:0] old;
      logic signed [ERR_W-1:0] d;
      w = rd_data[tgt_bank];
      upd_word.tag = ep_ff[tgt_bank];
      for (int c = 0; c < 3; c++) begin
         old = (w.tag == ep_ff[tgt_bank]) ? $signed(w.err[c]) : '0;
         d   = ERR_W'($signed(diff_ff[c]));
         upd_word.err[c] = ERR_W'(old + d * $signed(tgt_k));
      end
   end

   // RAM port steering
   always_comb begin
      for (int b = 0; b < 2; b++) begin
         rd_addr[b] = '0;
         wr_en[b]   = 1'b0;
         wr_addr[b] = '0;
         wr_data[b] = rd_data[b];
      end
      unique case (state_ff)
         ST_PASS: begin
            for (int b = 0; b < 2; b++) begin
               if (pass_cnt_ff < PASS_W'(ROW_SLOTS)) begin
                  rd_addr[b] = pass_cnt_ff[ADDR_W-1:0];
               end
               wr_en[b]   = (pass_cnt_ff != '0);
               wr_addr[b] = ADDR_W'(pass_cnt_ff - PASS_W'(1));
               // live entries keep data under the renumbered epoch
               wr_data[b].tag = (!pass_wipe_ff && (rd_data[b].tag == ep_ff[b])) ?
                                EPOCH_W'(b + 1) : '0;
            end
         end
         ST_RD: begin
            rd_addr[cur_sel_ff] = ADDR_W'(col_ff + COL_W'(1));
         end
         ST_UPD_RD: begin
            rd_addr[tgt_bank] = tgt_addr;
         end
         ST_UPD_WR: begin
            wr_en[tgt_bank]   = 1'b1;
            wr_addr[tgt_bank] = tgt_addr;
            wr_data[tgt_bank] = upd_word;
         end
         default: begin
         end
      endcase
   end

   // cell control
   always_comb begin
      ctl.clear    = (req_fire && (req_act == ACT_PIXEL) && !dither_ff) ||
                     (state_ff == ST_ADJ);
      ctl.step     = (state_ff == ST_SCAN) && (scan_cnt_ff < SCAN_W'(CELL_ENTRIES));
      ctl.slot     = scan_cnt_ff[SLOT_W-1:0];
      ctl.count    = count_eff;
      ctl.load     = req_fire && (req_act == ACT_LOAD);
      ctl.load_idx = req_tdata[IDX_W-1:0];
      ctl.load_rgb = req_tdata[31:8];
      ctl.pix      = adj_ff;
   end

   for (genvar b = 0; b < 2; b++) begin : g_bank
      sdpm_ram #(
         .WIDTH (ERR_WORD_W),
         .DEPTH (ROW_SLOTS)
      ) u_row (
         .clock   (clock),
         .wr_en   (wr_en[b]),
         .wr_addr (wr_addr[b]),
         .wr_data (wr_data[b]),
         .rd_addr (rd_addr[b]),
         .rd_data (rd_data[b])
      );
   end

   for (genvar j = 0; j < CELL_COUNT; j++) begin : g_cell
      sdpm_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cell_id   (CELL_SEL_W'(j)),
         .ctl       (ctl),
         .chain_in  ((j == 0) ? CAND_NONE : chain[(j == 0) ? 0 : j - 1]),
         .chain_out (chain[j])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_width_ff <= COL_W'(640);
         max_level_ff <= 8'd255;
         pal_count_ff <= CNT_W'(4);
         dither_ff    <= 1'b1;
         state_ff     <= ST_PASS;
         pass_cnt_ff  <= '0;
         pass_wipe_ff <= 1'b1;
         scan_cnt_ff  <= '0;
         upd_ff       <= '0;
         colpos_ff    <= '0;
         scan_fwd_ff  <= 1'b1;
         cur_sel_ff   <= 1'b0;
         ep_ff[0]     <= EPOCH_W'(1);
         ep_ff[1]     <= EPOCH_W'(2);
         ep_next_ff   <= EPOCH_W'(3);
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               REG_ROW_WIDTH:     row_width_ff <= csr_data;
               REG_MAX_LEVEL:     max_level_ff <= csr_data[7:0];
               REG_PALETTE_COUNT: pal_count_ff <= csr_data[CNT_W-1:0];
               REG_DITHER_ENABLE: dither_ff    <= csr_data[0];
            endcase
         end
         if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_PASS: begin
               if (pass_cnt_ff == PASS_W'(ROW_SLOTS)) begin
                  state_ff     <= ST_IDLE;
                  pass_wipe_ff <= 1'b0;
                  ep_ff[0]     <= EPOCH_W'(1);
                  ep_ff[1]     <= EPOCH_W'(2);
                  ep_next_ff   <= EPOCH_W'(3);
               end else begin
                  pass_cnt_ff <= pass_cnt_ff + PASS_W'(1);
               end
            end
            ST_IDLE: begin
               if (req_fire) begin
                  if (req_act == ACT_FRAME) begin
                     // fresh epochs empty both error rows
                     colpos_ff   <= '0;
                     scan_fwd_ff <= 1'b1;
                     ep_ff[0]    <= ep_next_ff;
                     ep_ff[1]    <= ep_next_ff + EPOCH_W'(1);
                     ep_next_ff  <= ep_next_ff + EPOCH_W'(2);
                     if (ep_next_ff + EPOCH_W'(2) >= EPOCH_W'(EPOCH_LIMIT)) begin
                        state_ff    <= ST_PASS;
                        pass_cnt_ff <= '0;
                     end
                  end else if (req_act == ACT_PIXEL) begin
                     pix_ff      <= req_tdata[31:8];
                     adj_ff      <= req_tdata[31:8];
                     pos_ff      <= pos_sel;
                     col_ff      <= col_sel;
                     fwd_ff      <= fwd_sel;
                     dith_ff     <= dither_ff;
                     last_ff     <= (pos_sel == width_eff - COL_W'(1));
                     scan_cnt_ff <= '0;
                     state_ff    <= dither_ff ? ST_RD : ST_SCAN;
                  end
               end
            end
            ST_RD: begin
               state_ff <= ST_ADJ;
            end
            ST_ADJ: begin
               adj_ff   <= adj_in;
               state_ff <= ST_SCAN;
            end
            ST_SCAN: begin
               if (scan_cnt_ff == SCAN_W'(SCAN_LAST)) begin
                  best_ff  <= chain[CELL_COUNT-1];
                  diff_ff  <= diff_in;
                  upd_ff   <= '0;
                  state_ff <= dith_ff ? ST_UPD_RD : ST_DONE;
               end else begin
                  scan_cnt_ff <= scan_cnt_ff + SCAN_W'(1);
               end
            end
            ST_UPD_RD: begin
               state_ff <= ST_UPD_WR;
            end
            ST_UPD_WR: begin
               upd_ff   <= upd_ff + 2'd1;
               state_ff <= (upd_ff == 2'd3) ? ST_DONE : ST_UPD_RD;
            end
            ST_DONE: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= {best_ff.rgb, best_ff.idx};
                  rsp_last_ff  <= last_ff;
                  state_ff     <= ST_IDLE;
                  if (!last_ff) begin
                     colpos_ff <= pos_ff + COL_W'(1);
                  end else begin
                     colpos_ff <= '0;
                     if (dith_ff) begin
                        // next row becomes current; old current is emptied
                        cur_sel_ff         <= !cur_sel_ff;
                        scan_fwd_ff        <= !scan_fwd_ff;
                        ep_ff[cur_sel_ff]  <= ep_next_ff;
                        ep_next_ff         <= ep_next_ff + EPOCH_W'(1);
                        if (ep_next_ff + EPOCH_W'(1) >= EPOCH_W'(EPOCH_LIMIT)) begin
                           state_ff    <= ST_PASS;
                           pass_cnt_ff <= '0;
                        end
                     end
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule
`default_nettype wire

[hdl/sdpm_checker.sv]
// Port-level checker for the palette mapper, bound to the top level.
`default_nettype none
`include "serpentine_dither_palette_mapper_defines.svh"
module sdpm_checker
   import sdpm_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic [1:0]  req_tuser,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [31:0] rsp_tdata,
   input wire logic        rsp_tlast
);

   // a stalled result holds
   `SDPM_ASSERT(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast), "rsp changed while stalled")

   // reset leaves no result and runs the row sweep first
   `SDPM_ASSERT_RST(a_reset_quiet, reset |=> !rsp_tvalid && !req_tready, "not quiet after reset")

   // no transaction produces its result in the very next cycle
   `SDPM_ASSERT(a_no_instant_rsp, req_tvalid && req_tready |=> !$rose(rsp_tvalid), "result too early")

   // a pixel occupies the block
   `SDPM_ASSERT(a_pixel_busy, req_tvalid && req_tready && req_tuser == ACT_PIXEL |=> !req_tready, "pixel not holding off input")

endmodule

bind serpentine_dither_palette_mapper sdpm_checker u_sdpm_checker (.*);
`default_nettype wire
